FILE: rtl/amss_pkg.sv
// Shared types, constants and the glyph decoder of the millivolt scan block.
package amss_pkg;

  localparam int FS_BITS        = 14;
  localparam int MASK_BITS      = 8;
  localparam int MV_BITS        = 14;
  localparam int BCD_BITS       = 4;
  localparam int STORE_DEPTH    = 8;
  localparam int POS_BITS       = 3;
  localparam int SEG_BITS       = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 14;
  localparam int LANE_STAGES    = 4;

  localparam logic [MV_BITS-1:0]       MV_MAX       = 14'd9999;
  localparam logic [FS_BITS-1:0]       FS_RESET     = 14'd4600;
  localparam logic [MASK_BITS-1:0]     MASK_RESET   = 8'd136;
  localparam logic [SEG_BITS-1:0]      DP_SEGMENT   = 8'h80;

  localparam logic                     OP_LOAD      = 1'b0;
  localparam logic                     OP_SCAN      = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DP_MASK    = 2'd1;

  // reciprocals for the decimal split
  localparam logic [13:0] RECIP_1000 = 14'd8389;  // >> 23, exact below 10000
  localparam logic [5:0]  RECIP_100  = 6'd41;     // >> 12, exact below 1000
  localparam logic [7:0]  RECIP_10   = 8'd205;    // >> 11, exact below 100

  typedef struct packed {
    logic [BCD_BITS-1:0] d3;
    logic [BCD_BITS-1:0] d2;
    logic [BCD_BITS-1:0] d1;
    logic [BCD_BITS-1:0] d0;
  } digits_t;

  typedef struct packed {
    logic valid;
    logic opcode;
  } head_t;

  function automatic logic [SEG_BITS-1:0] glyph(input logic [BCD_BITS-1:0] code);
    logic [SEG_BITS-1:0] seg;
    unique case (code)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      default: seg = 8'h71;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/amss_lane.sv
// One channel lane: scale a sample to millivolts and split it into four decimal digits.
module amss_lane #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                  clk,
  input  logic [amss_pkg::LANE_STAGES-1:0]      en,
  input  logic [SAMPLE_BITS-1:0]                sample,
  input  logic [amss_pkg::FS_BITS-1:0]          full_scale,
  output amss_pkg::digits_t                     digits
);
  import amss_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + FS_BITS;

  logic [PROD_BITS-1:0] product;
  logic [BCD_BITS-1:0]  s2_thou;
  logic [9:0]           s2_rem;
  logic [BCD_BITS-1:0]  s3_thou;
  logic [BCD_BITS-1:0]  s3_hund;
  logic [6:0]           s3_rem;

  logic [MV_BITS-1:0]   mv_raw;
  logic [MV_BITS-1:0]   mv_sat;
  logic [27:0]          thou_prod;
  logic [BCD_BITS-1:0]  thou;
  logic [MV_BITS-1:0]   rem1000_wide;
  logic [15:0]          hund_prod;
  logic [BCD_BITS-1:0]  hund;
  logic [9:0]           rem100_wide;
  logic [14:0]          tens_prod;
  logic [BCD_BITS-1:0]  tens;
  logic [6:0]           units_wide;

  assign mv_raw       = product[SAMPLE_BITS +: MV_BITS];
  assign mv_sat       = (mv_raw > MV_MAX) ? MV_MAX : mv_raw;
  assign thou_prod    = 28'(mv_sat) * 28'(RECIP_1000);
  assign thou         = thou_prod[23 +: BCD_BITS];
  assign rem1000_wide = mv_sat - 14'(thou) * 14'd1000;

  assign hund_prod    = 16'(s2_rem) * 16'(RECIP_100);
  assign hund         = hund_prod[12 +: BCD_BITS];
  assign rem100_wide  = s2_rem - 10'(hund) * 10'd100;

  assign tens_prod    = 15'(s3_rem) * 15'(RECIP_10);
  assign tens         = tens_prod[11 +: BCD_BITS];
  assign units_wide   = s3_rem - 7'(tens) * 7'd10;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      product <= PROD_BITS'(sample) * PROD_BITS'(full_scale);
    end
    if (en[1]) begin
      s2_thou <= thou;
      s2_rem  <= rem1000_wide[9:0];
    end
    if (en[2]) begin
      s3_thou <= s2_thou;
      s3_hund <= hund;
      s3_rem  <= rem100_wide[6:0];
    end
    if (en[3]) begin
      digits.d3 <= s3_thou;
      digits.d2 <= s3_hund;
      digits.d1 <= tens;
      digits.d0 <= units_wide[BCD_BITS-1:0];
    end
  end

endmodule

FILE: rtl/amss_merge.sv
// Merge stage: digit store update, scan position and the registered display output.
module amss_merge #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  amss_pkg::head_t                   head,
  output logic                              head_ready,
  input  amss_pkg::digits_t                 digits_ch0,
  input  amss_pkg::digits_t                 digits_ch1,
  input  logic [amss_pkg::MASK_BITS-1:0]    dp_mask,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [amss_pkg::SEG_BITS-1:0]     segment_pattern,
  output logic [amss_pkg::SEG_BITS-1:0]     digit_enable
);
  import amss_pkg::*;

  localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(DIGIT_COUNT - 1);

  logic [BCD_BITS-1:0] digit_store [STORE_DEPTH];
  logic [POS_BITS-1:0] scan_position;
  logic [POS_BITS-1:0] scan_position_next;
  logic                out_free;
  logic                do_load;
  logic                do_scan;
  logic [SEG_BITS-1:0] pattern;

  assign out_free   = !out_valid || out_ready;
  assign head_ready = (head.opcode == OP_LOAD) || out_free;
  assign do_load    = head.valid && (head.opcode == OP_LOAD);
  assign do_scan    = head.valid && (head.opcode == OP_SCAN) && out_free;

  assign scan_position_next = (scan_position == LAST_POS) ? '0 : scan_position + 1'b1;
  assign pattern = glyph(digit_store[scan_position])
                 | (dp_mask[scan_position] ? DP_SEGMENT : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        digit_store[k] <= '0;
      end
      scan_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (do_load) begin
        digit_store[0] <= digits_ch0.d0;
        digit_store[1] <= digits_ch0.d1;
        digit_store[2] <= digits_ch0.d2;
        digit_store[3] <= digits_ch0.d3;
        digit_store[4] <= digits_ch1.d0;
        digit_store[5] <= digits_ch1.d1;
        digit_store[6] <= digits_ch1.d2;
        digit_store[7] <= digits_ch1.d3;
      end
      if (do_scan) begin
        scan_position <= scan_position_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_scan) begin
      segment_pattern <= pattern;
      digit_enable    <= SEG_BITS'(1) << scan_position;
    end
  end

endmodule

FILE: rtl/adc_millivolt_seven_segment_scan_top.sv
// Top level of the millivolt read-out and seven-segment scan block.
// Input channel (in_valid/in_ready): opcode 0 loads a sample pair, opcode 1
// advances the display scan by one digit. Config channel (cfg_valid/cfg_ready,
// always ready): index 0 full-scale millivolts, index 1 decimal point mask;
// write only while the block is idle.
// Each load goes through two lanes, one per channel, of four stages each
// (multiply, thousands, hundreds, tens/units) and then a merge stage that
// writes the digit store. A scan item reads the store in the merge stage and
// drives segment_pattern/digit_enable on the out channel (out_valid/out_ready).
// Throughput: one item per cycle while out_ready does not hold a scan item
// back, set by the lane pipeline; loads produce no output transfer.
// When the receiver stalls, the pipeline keeps accepting items until its five
// stages are full, then in_ready drops. Reset clears the digit store to zero,
// the scan position to digit 0, the pipeline valid bits, and loads the
// registers with 4600 mV and mask 136.
module adc_millivolt_seven_segment_scan_top #(
  parameter int DIGIT_COUNT = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  opcode,
  input  logic [SAMPLE_BITS-1:0]                sample_ch0,
  input  logic [SAMPLE_BITS-1:0]                sample_ch1,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [amss_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [amss_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [amss_pkg::SEG_BITS-1:0]         segment_pattern,
  output logic [amss_pkg::SEG_BITS-1:0]         digit_enable
);
  import amss_pkg::*;

  logic [FS_BITS-1:0]     full_scale_millivolts;
  logic [MASK_BITS-1:0]   decimal_point_mask;
  logic [LANE_STAGES-1:0] stage_valid;
  logic [LANE_STAGES-1:0] stage_op;
  logic [LANE_STAGES-1:0] stage_en;
  logic                   head_ready;
  head_t                  head;
  digits_t                digits_ch0;
  digits_t                digits_ch1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_millivolts <= FS_RESET;
      decimal_point_mask    <= MASK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FULL_SCALE: full_scale_millivolts <= cfg_data[FS_BITS-1:0];
        REG_DP_MASK:    decimal_point_mask    <= cfg_data[MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stage_en[LANE_STAGES-1] = !stage_valid[LANE_STAGES-1] || head_ready;
    for (int k = LANE_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
  end

  assign in_ready = stage_en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < LANE_STAGES; k++) begin
        if (stage_en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      stage_op[0] <= opcode;
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (stage_en[k]) begin
        stage_op[k] <= stage_op[k-1];
      end
    end
  end

  assign head.valid  = stage_valid[LANE_STAGES-1];
  assign head.opcode = stage_op[LANE_STAGES-1];

  amss_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_ch0 (
    .clk        (clk),
    .en         (stage_en),
    .sample     (sample_ch0),
    .full_scale (full_scale_millivolts),
    .digits     (digits_ch0)
  );

  amss_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_ch1 (
    .clk        (clk),
    .en         (stage_en),
    .sample     (sample_ch1),
    .full_scale (full_scale_millivolts),
    .digits     (digits_ch1)
  );

  amss_merge #(.DIGIT_COUNT(DIGIT_COUNT)) u_merge (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_ready      (head_ready),
    .digits_ch0      (digits_ch0),
    .digits_ch1      (digits_ch1),
    .dp_mask         (decimal_point_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .segment_pattern (segment_pattern),
    .digit_enable    (digit_enable)
  );

endmodule
